### rtl/core/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, constants and helpers of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int SOURCE_PIXELS_DEF = 65536;
  localparam int MAX_LINE_DEF      = 1024;

  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = 26;
  localparam int INT_W      = ACC_W - FRAC_BITS;
  localparam int DIM_W      = 11;
  localparam int BPP_W      = 3;
  localparam int INDEX_W    = 16;
  localparam int PIXEL_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_X_STEP,
    REG_Y_STEP,
    REG_BYTES_PER_PIXEL
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] source_index;
    logic [PIXEL_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    logic               end_of_row;
    logic               end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
    logic [ACC_W-1:0] x_step;
    logic [ACC_W-1:0] y_step;
    logic [BPP_W-1:0] bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               end_of_row;
    logic               end_of_frame;
    logic [PIXEL_W-1:0] mask;
  } emit_t;

  function automatic logic [PIXEL_W-1:0] pixel_mask(input logic [BPP_W-1:0] nbytes);
    logic [PIXEL_W-1:0] m;
    case (nbytes)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor scaler over a source frame held in on-chip memory.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock: busy stays low, so every cycle
// with start high is accepted. A load writes its pixel into the frame memory
// and gives no result. An emit gives its result in the cycle after acceptance,
// held for exactly one cycle under out_valid; the receiver cannot stall, so
// it must take every result as it comes. That delay is the registered read
// of the frame memory. A load is visible to an emit accepted in the next
// cycle. The memory needs no clearing pass after reset; pixels never loaded
// read as unknown. SOURCE_PIXELS must be a power of two, and source indices
// and read addresses wrap modulo it.
module nearest_neighbor_image_scaler #(
  parameter int SOURCE_PIXELS = nnis_pkg::SOURCE_PIXELS_DEF,
  parameter int MAX_LINE      = nnis_pkg::MAX_LINE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  nnis_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output nnis_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [nnis_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int AW = $clog2(SOURCE_PIXELS);

  nnis_pkg::cfg_t               cfg;
  nnis_pkg::emit_t              st;
  logic                         accept;
  logic                         load;
  logic                         emit;
  logic [AW+nnis_pkg::INDEX_W-1:0] idx_ext;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic [nnis_pkg::PIXEL_W-1:0] rd_data;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign load    = accept & (in_item.operation == nnis_pkg::OP_LOAD);
  assign emit    = accept & (in_item.operation == nnis_pkg::OP_EMIT);
  assign idx_ext = {{AW{1'b0}}, in_item.source_index};
  assign wr_addr = idx_ext[AW-1:0];

  nnis_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nnis_addr_gen #(
    .SOURCE_PIXELS (SOURCE_PIXELS),
    .MAX_LINE      (MAX_LINE)
  ) u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .emit    (emit),
    .cfg     (cfg),
    .rd_addr (rd_addr),
    .st      (st)
  );

  nnis_frame_mem #(
    .SOURCE_PIXELS (SOURCE_PIXELS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load),
    .wr_addr (wr_addr),
    .wr_data (in_item.pixel_value),
    .rd_en   (emit),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid             = st.valid;
  assign out_item.out_pixel    = rd_data & st.mask;
  assign out_item.end_of_row   = st.end_of_row;
  assign out_item.end_of_frame = st.end_of_frame;

  a_emit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("accepted emit gave no result");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(emit))
    else $error("result without an accepted emit");

  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.end_of_frame) |-> out_item.end_of_row)
    else $error("frame end without row end");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !$past(emit)) |-> !out_valid)
    else $error("load produced a result");

endmodule

### rtl/core/nnis_cfg_regs.sv
// ----------------------------------------------------------------------------
// nnis_cfg_regs
// APB-style register file holding the scaler geometry, steps and pixel size.
// ----------------------------------------------------------------------------
module nnis_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [nnis_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output nnis_pkg::cfg_t                    cfg
);

  nnis_pkg::cfg_t   cfg_r;
  nnis_pkg::cfg_t   cfg_nxt;
  nnis_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = nnis_pkg::reg_idx_t'(paddr[nnis_pkg::CFG_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        nnis_pkg::REG_SRC_WIDTH:       cfg_nxt.src_width       = pwdata[nnis_pkg::DIM_W-1:0];
        nnis_pkg::REG_DST_WIDTH:       cfg_nxt.dst_width       = pwdata[nnis_pkg::DIM_W-1:0];
        nnis_pkg::REG_DST_HEIGHT:      cfg_nxt.dst_height      = pwdata[nnis_pkg::DIM_W-1:0];
        nnis_pkg::REG_X_STEP:          cfg_nxt.x_step          = pwdata[nnis_pkg::ACC_W-1:0];
        nnis_pkg::REG_Y_STEP:          cfg_nxt.y_step          = pwdata[nnis_pkg::ACC_W-1:0];
        nnis_pkg::REG_BYTES_PER_PIXEL: cfg_nxt.bytes_per_pixel = pwdata[nnis_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      nnis_pkg::REG_SRC_WIDTH:       prdata = nnis_pkg::CFG_DATA_W'(cfg_r.src_width);
      nnis_pkg::REG_DST_WIDTH:       prdata = nnis_pkg::CFG_DATA_W'(cfg_r.dst_width);
      nnis_pkg::REG_DST_HEIGHT:      prdata = nnis_pkg::CFG_DATA_W'(cfg_r.dst_height);
      nnis_pkg::REG_X_STEP:          prdata = nnis_pkg::CFG_DATA_W'(cfg_r.x_step);
      nnis_pkg::REG_Y_STEP:          prdata = nnis_pkg::CFG_DATA_W'(cfg_r.y_step);
      nnis_pkg::REG_BYTES_PER_PIXEL: prdata = nnis_pkg::CFG_DATA_W'(cfg_r.bytes_per_pixel);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width       <= nnis_pkg::DIM_W'(1);
      cfg_r.dst_width       <= nnis_pkg::DIM_W'(1);
      cfg_r.dst_height      <= nnis_pkg::DIM_W'(1);
      cfg_r.x_step          <= nnis_pkg::ACC_W'(65536);
      cfg_r.y_step          <= nnis_pkg::ACC_W'(65536);
      cfg_r.bytes_per_pixel <= nnis_pkg::BPP_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/nnis_frame_mem.sv
// ----------------------------------------------------------------------------
// nnis_frame_mem
// Source frame memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nnis_frame_mem #(
  parameter int SOURCE_PIXELS = nnis_pkg::SOURCE_PIXELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [$clog2(SOURCE_PIXELS)-1:0]      wr_addr,
  input  logic [nnis_pkg::PIXEL_W-1:0]          wr_data,
  input  logic                                  rd_en,
  input  logic [$clog2(SOURCE_PIXELS)-1:0]      rd_addr,
  output logic [nnis_pkg::PIXEL_W-1:0]          rd_data
);

  logic [nnis_pkg::PIXEL_W-1:0] mem [SOURCE_PIXELS];
  logic [nnis_pkg::PIXEL_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/nnis_addr_gen.sv
// ----------------------------------------------------------------------------
// nnis_addr_gen
// Raster walker: 10.16 accumulators, row and column counters, read address
// and registered row/frame end flags for each emitted pixel.
// ----------------------------------------------------------------------------
module nnis_addr_gen #(
  parameter int SOURCE_PIXELS = nnis_pkg::SOURCE_PIXELS_DEF,
  parameter int MAX_LINE      = nnis_pkg::MAX_LINE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  emit,
  input  nnis_pkg::cfg_t                        cfg,
  output logic [$clog2(SOURCE_PIXELS)-1:0]      rd_addr,
  output nnis_pkg::emit_t                       st
);

  localparam int AW    = $clog2(SOURCE_PIXELS);
  localparam int CNT_W = $clog2(MAX_LINE);
  localparam int SZ_W  = CNT_W + 1;
  localparam int SUM_W = nnis_pkg::INT_W + nnis_pkg::DIM_W;

  logic [nnis_pkg::ACC_W-1:0] x_acc_r, x_acc_nxt;
  logic [nnis_pkg::ACC_W-1:0] y_acc_r, y_acc_nxt;
  logic [CNT_W-1:0]           col_r, col_nxt;
  logic [CNT_W-1:0]           row_r, row_nxt;
  nnis_pkg::emit_t            st_r, st_nxt;

  logic [SZ_W-1:0]  width_c, height_c;
  logic [SZ_W-1:0]  col_inc, row_inc;
  logic             row_end, frame_end;
  logic [SUM_W-1:0] prod, addr_sum;

  // source address from the integer parts of the accumulators
  assign prod = {{nnis_pkg::DIM_W{1'b0}}, y_acc_r[nnis_pkg::ACC_W-1:nnis_pkg::FRAC_BITS]}
              * {{nnis_pkg::INT_W{1'b0}}, cfg.src_width};
  assign addr_sum = prod + SUM_W'(x_acc_r[nnis_pkg::ACC_W-1:nnis_pkg::FRAC_BITS]);
  assign rd_addr  = addr_sum[AW-1:0];
  assign st       = st_r;

  always_comb begin
    if (cfg.dst_width == '0) begin
      width_c = SZ_W'(1);
    end else if (32'(cfg.dst_width) > 32'(MAX_LINE)) begin
      width_c = SZ_W'(MAX_LINE);
    end else begin
      width_c = SZ_W'(cfg.dst_width);
    end
    if (cfg.dst_height == '0) begin
      height_c = SZ_W'(1);
    end else if (32'(cfg.dst_height) > 32'(MAX_LINE)) begin
      height_c = SZ_W'(MAX_LINE);
    end else begin
      height_c = SZ_W'(cfg.dst_height);
    end
  end

  always_comb begin
    col_inc   = {1'b0, col_r} + SZ_W'(1);
    row_inc   = {1'b0, row_r} + SZ_W'(1);
    row_end   = col_inc >= width_c;
    frame_end = row_end && (row_inc >= height_c);

    x_acc_nxt = x_acc_r;
    y_acc_nxt = y_acc_r;
    col_nxt   = col_r;
    row_nxt   = row_r;

    st_nxt              = st_r;
    st_nxt.valid        = emit;
    st_nxt.end_of_row   = row_end;
    st_nxt.end_of_frame = frame_end;
    st_nxt.mask         = nnis_pkg::pixel_mask(cfg.bytes_per_pixel);

    if (emit) begin
      if (!row_end) begin
        col_nxt   = col_inc[CNT_W-1:0];
        x_acc_nxt = x_acc_r + cfg.x_step;
      end else begin
        col_nxt   = '0;
        x_acc_nxt = '0;
        if (frame_end) begin
          row_nxt   = '0;
          y_acc_nxt = '0;
        end else begin
          row_nxt   = row_inc[CNT_W-1:0];
          y_acc_nxt = y_acc_r + cfg.y_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r  <= '0;
      y_acc_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      st_r     <= '0;
    end else begin
      x_acc_r  <= x_acc_nxt;
      y_acc_r  <= y_acc_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      st_r     <= st_nxt;
    end
  end

endmodule

### bench/tb_nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_image_scaler
// Self-checking bench for the nearest-neighbor image scaler. A directed table
// covers reset settings, pixel sizes, index and accumulator wrap, zero and
// oversized line lengths and a setting change in the middle of a frame. Random
// phases then rewrite the registers over the APB port and mix loads with
// emits. Each emit result is checked against its table row if typed, else
// against a predictor of the frame memory, step accumulators and row/col counters.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_image_scaler;

  typedef struct packed {
    logic                                 is_cfg;
    nnis_pkg::reg_idx_t                   reg_sel;
    logic [31:0]                          cfg_val;
    nnis_pkg::op_t                        op;
    logic [nnis_pkg::INDEX_W-1:0]         idx;
    logic [nnis_pkg::PIXEL_W-1:0]         val;
    logic                                 typed;
    nnis_pkg::out_item_t                  want;
  } step_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  nnis_pkg::in_item_t              in_item;
  logic                            out_valid;
  nnis_pkg::out_item_t             out_item;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [nnis_pkg::CFG_ADDR_W-1:0] paddr;
  logic [nnis_pkg::CFG_DATA_W-1:0] pwdata;
  logic [nnis_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  nnis_pkg::cfg_t                scale_cfg;
  logic [nnis_pkg::ACC_W-1:0]    x_acc;
  logic [nnis_pkg::ACC_W-1:0]    y_acc;
  int unsigned                   col_cnt;
  int unsigned                   row_cnt;
  logic [nnis_pkg::PIXEL_W-1:0]  frame_mem [0:65535];
  bit                            loaded [0:65535];

  nnis_pkg::out_item_t pending_pixels[$];
  nnis_pkg::out_item_t want;
  step_row_t           directed_rows[$];
  int                  mismatches;
  int                  items_sent;
  bit                  idle_on;

  nearest_neighbor_image_scaler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned line_len(logic [nnis_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return 32'(v);
  endfunction

  function automatic logic [nnis_pkg::PIXEL_W-1:0] size_mask(logic [nnis_pkg::BPP_W-1:0] n);
    if (n == 0) return '0;
    if (n >= 4) return '1;
    return (32'd1 << (8 * n)) - 32'd1;
  endfunction

  function automatic logic [nnis_pkg::INDEX_W-1:0] read_index();
    int unsigned a;
    a = 32'(y_acc[nnis_pkg::ACC_W-1:nnis_pkg::FRAC_BITS]) * 32'(scale_cfg.src_width)
      + 32'(x_acc[nnis_pkg::ACC_W-1:nnis_pkg::FRAC_BITS]);
    return a[nnis_pkg::INDEX_W-1:0];
  endfunction

  function automatic nnis_pkg::out_item_t scale_emit();
    nnis_pkg::out_item_t r;
    logic                row_end;
    logic                frame_end;
    r.out_pixel = frame_mem[read_index()] & size_mask(scale_cfg.bytes_per_pixel);
    row_end = (col_cnt + 1) >= line_len(scale_cfg.dst_width);
    frame_end = row_end && ((row_cnt + 1) >= line_len(scale_cfg.dst_height));
    if (!row_end) begin
      col_cnt++;
      x_acc = x_acc + scale_cfg.x_step;
    end else begin
      col_cnt = 0;
      x_acc = '0;
      if (frame_end) begin
        row_cnt = 0;
        y_acc = '0;
      end else begin
        row_cnt++;
        y_acc = y_acc + scale_cfg.y_step;
      end
    end
    r.end_of_row = row_end;
    r.end_of_frame = frame_end;
    return r;
  endfunction

  function automatic step_row_t cfg_row(nnis_pkg::reg_idx_t r, logic [31:0] v);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_sel = r;
    s.cfg_val = v;
    return s;
  endfunction

  function automatic step_row_t load_row(logic [nnis_pkg::INDEX_W-1:0] i,
                                         logic [nnis_pkg::PIXEL_W-1:0] v);
    step_row_t s;
    s = '0;
    s.op = nnis_pkg::OP_LOAD;
    s.idx = i;
    s.val = v;
    return s;
  endfunction

  function automatic step_row_t emit_row(bit typed, logic [nnis_pkg::PIXEL_W-1:0] px,
                                         bit eor, bit eof);
    step_row_t s;
    s = '0;
    s.op = nnis_pkg::OP_EMIT;
    s.typed = typed;
    s.want.out_pixel = px;
    s.want.end_of_row = eor;
    s.want.end_of_frame = eof;
    return s;
  endfunction

  task automatic flag(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_item(nnis_pkg::in_item_t it, bit typed, nnis_pkg::out_item_t typed_want);
    nnis_pkg::out_item_t predicted;
    if (idle_on && $urandom_range(99) < 4) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (it.operation == nnis_pkg::OP_EMIT) begin
      predicted = scale_emit();
      pending_pixels.push_back(typed ? typed_want : predicted);
    end else begin
      frame_mem[it.source_index] = it.pixel_value;
      loaded[it.source_index] = 1'b1;
    end
  endtask

  task automatic send_load(logic [nnis_pkg::INDEX_W-1:0] idx,
                           logic [nnis_pkg::PIXEL_W-1:0] val);
    nnis_pkg::in_item_t it;
    it.operation = nnis_pkg::OP_LOAD;
    it.source_index = idx;
    it.pixel_value = val;
    send_item(it, 1'b0, '0);
  endtask

  // the pixel the next emit reads gets loaded first if it never was
  task automatic send_emit(bit typed, nnis_pkg::out_item_t w);
    nnis_pkg::in_item_t it;
    if (!loaded[read_index()]) send_load(read_index(), $urandom());
    it.operation = nnis_pkg::OP_EMIT;
    it.source_index = nnis_pkg::INDEX_W'($urandom());
    it.pixel_value = $urandom();
    send_item(it, typed, w);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(nnis_pkg::reg_idx_t r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= nnis_pkg::CFG_ADDR_W'(4 * int'(r));
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      nnis_pkg::REG_SRC_WIDTH:       scale_cfg.src_width = v[nnis_pkg::DIM_W-1:0];
      nnis_pkg::REG_DST_WIDTH:       scale_cfg.dst_width = v[nnis_pkg::DIM_W-1:0];
      nnis_pkg::REG_DST_HEIGHT:      scale_cfg.dst_height = v[nnis_pkg::DIM_W-1:0];
      nnis_pkg::REG_X_STEP:          scale_cfg.x_step = v[nnis_pkg::ACC_W-1:0];
      nnis_pkg::REG_Y_STEP:          scale_cfg.y_step = v[nnis_pkg::ACC_W-1:0];
      nnis_pkg::REG_BYTES_PER_PIXEL: scale_cfg.bytes_per_pixel = v[nnis_pkg::BPP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        flag("result with no transaction pending");
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.out_pixel !== want.out_pixel)
          flag($sformatf("out_pixel got %h expected %h", out_item.out_pixel, want.out_pixel));
        if (out_item.end_of_row !== want.end_of_row)
          flag($sformatf("end_of_row got %b expected %b", out_item.end_of_row,
                         want.end_of_row));
        if (out_item.end_of_frame !== want.end_of_frame)
          flag($sformatf("end_of_frame got %b expected %b", out_item.end_of_frame,
                         want.end_of_frame));
      end
    end
  end

  initial begin : main
    step_row_t   row;
    int unsigned v;
    int          n;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    items_sent = 0;
    idle_on = 1'b1;
    scale_cfg.src_width = 1;
    scale_cfg.dst_width = 1;
    scale_cfg.dst_height = 1;
    scale_cfg.x_step = 26'h10000;
    scale_cfg.y_step = 26'h10000;
    scale_cfg.bytes_per_pixel = 1;
    x_acc = '0;
    y_acc = '0;
    col_cnt = 0;
    row_cnt = 0;

    // reset settings: 1x1 frame, one byte per pixel
    directed_rows.push_back(load_row(16'h0000, 32'hA5A5_5A5A));
    directed_rows.push_back(emit_row(1, 32'h0000_005A, 1, 1));
    directed_rows.push_back(load_row(16'hFFFF, 32'hFFFF_FFFF));
    directed_rows.push_back(load_row(16'h0000, 32'h0000_0000));
    directed_rows.push_back(emit_row(1, 32'h0000_0000, 1, 1));
    directed_rows.push_back(load_row(16'h0000, 32'hDEAD_BEEF));
    // pixel sizes
    directed_rows.push_back(cfg_row(nnis_pkg::REG_BYTES_PER_PIXEL, 4));
    directed_rows.push_back(emit_row(1, 32'hDEAD_BEEF, 1, 1));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_BYTES_PER_PIXEL, 0));
    directed_rows.push_back(emit_row(1, 32'h0000_0000, 1, 1));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_BYTES_PER_PIXEL, 7));
    directed_rows.push_back(emit_row(1, 32'hDEAD_BEEF, 1, 1));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_BYTES_PER_PIXEL, 3));
    directed_rows.push_back(emit_row(1, 32'h00AD_BEEF, 1, 1));
    // second row reads index 65536, which wraps to 0
    directed_rows.push_back(cfg_row(nnis_pkg::REG_BYTES_PER_PIXEL, 2));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_SRC_WIDTH, 1024));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_DST_HEIGHT, 2));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_Y_STEP, 32'h0040_0000));
    directed_rows.push_back(emit_row(1, 32'h0000_BEEF, 1, 0));
    directed_rows.push_back(emit_row(1, 32'h0000_BEEF, 1, 1));
    // x accumulator wrap, zero height acts as one
    directed_rows.push_back(cfg_row(nnis_pkg::REG_X_STEP, 32'h03FF_FFFF));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_DST_WIDTH, 3));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_DST_HEIGHT, 0));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_BYTES_PER_PIXEL, 1));
    directed_rows.push_back(emit_row(1, 32'h0000_00EF, 0, 0));
    directed_rows.push_back(emit_row(0, '0, 0, 0));
    directed_rows.push_back(emit_row(0, '0, 0, 0));
    // oversized width, zero steps
    directed_rows.push_back(cfg_row(nnis_pkg::REG_DST_WIDTH, 2047));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_X_STEP, 0));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_Y_STEP, 0));
    directed_rows.push_back(emit_row(1, 32'h0000_00EF, 0, 0));
    // equal size copy, entered mid-row
    directed_rows.push_back(cfg_row(nnis_pkg::REG_SRC_WIDTH, 4));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_DST_WIDTH, 4));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_DST_HEIGHT, 2));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_X_STEP, 32'h0001_0000));
    directed_rows.push_back(cfg_row(nnis_pkg::REG_Y_STEP, 32'h0001_0000));
    repeat (6) directed_rows.push_back(emit_row(0, '0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain();
        cfg_write(row.reg_sel, row.cfg_val);
      end else if (row.op == nnis_pkg::OP_LOAD) begin
        send_load(row.idx, row.val);
      end else begin
        send_emit(row.typed, row.want);
      end
    end

    while (items_sent < 430) begin
      drain();
      for (int r = 0; r < 6; r++) begin
        if ($urandom_range(9) < 7) begin
          case (nnis_pkg::reg_idx_t'(r))
            nnis_pkg::REG_SRC_WIDTH: begin
              case ($urandom_range(9))
                0: v = 1;
                1: v = 1024;
                2: v = 2047;
                default: v = $urandom_range(1, 40);
              endcase
            end
            nnis_pkg::REG_DST_WIDTH, nnis_pkg::REG_DST_HEIGHT: begin
              case ($urandom_range(9))
                0: v = 0;
                1: v = 1024;
                2: v = 2047;
                3: v = 1;
                default: v = $urandom_range(1, 8);
              endcase
            end
            nnis_pkg::REG_X_STEP: begin
              case ($urandom_range(9))
                0: v = 0;
                1: v = 32'h03FF_FFFF;
                2: v = $urandom() & 32'h03FF_FFFF;
                default: v = ((32'(scale_cfg.src_width) << 16)
                              / line_len(scale_cfg.dst_width)) & 32'h03FF_FFFF;
              endcase
            end
            nnis_pkg::REG_Y_STEP: begin
              case ($urandom_range(9))
                0: v = 0;
                1: v = 32'h03FF_FFFF;
                2: v = $urandom() & 32'h03FF_FFFF;
                default: v = (($urandom_range(1, 16) << 16)
                              / line_len(scale_cfg.dst_height)) & 32'h03FF_FFFF;
              endcase
            end
            default: v = $urandom_range(0, 7);
          endcase
          cfg_write(nnis_pkg::reg_idx_t'(r), v);
        end
      end
      repeat ($urandom_range(10, 50)) begin
        // one long stretch without sender gaps
        idle_on = !(items_sent >= 180 && items_sent < 320);
        if ($urandom_range(99) < 65)
          send_emit(1'b0, '0);
        else if ($urandom_range(1) == 1)
          send_load(nnis_pkg::INDEX_W'($urandom()), $urandom());
        else
          send_load(nnis_pkg::INDEX_W'(32'(read_index()) + $urandom_range(0, 7)),
                    $urandom());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    n = 0;
    while (pending_pixels.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    if (pending_pixels.size() != 0)
      flag($sformatf("%0d results never arrived", pending_pixels.size()));
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
